>>> rtl/lrp_pkg.sv
// Shared types and constants of the log record parser.
`timescale 1ns / 1ps

package lrp_pkg;

    // Version bytes; any first byte below VERSION_MIN starts a legacy record.
    localparam logic [7:0] VERSION_LEGACY = 8'd0;
    localparam logic [7:0] VERSION_MIN    = 8'h7f;
    localparam logic [7:0] VERSION_WIDE   = 8'h80;
    localparam logic [7:0] VERSION_ENC    = 8'd129;

    localparam logic [1:0] STORE_CACHE   = 2'd0;
    localparam logic [1:0] STORE_PERSIST = 2'd1;
    localparam logic [1:0] STORE_NONE    = 2'd2;

    localparam int RESULT_FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_KEY     = 2'd0,
        KIND_ARG     = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_TRUNC  = 2'd1,
        STATUS_BADVER = 2'd2
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [31:0] arg_index;
        status_t     status;
        logic [7:0]  command;
        logic [7:0]  version;
        logic [15:0] key_length;
        logic [6:0]  db_id;
        logic [1:0]  store_type;
        logic [31:0] record_ts;
        logic [31:0] arg_count;
        logic        last;
    } result_t;

    // Which of the two result slots a byte fills; the low slot always goes first.
    typedef struct packed {
        logic lo;
        logic hi;
    } push_t;

endpackage

>>> rtl/lrp_parse.sv
// Record parsing state machine: one input byte per cycle while in_accept is high, up to two results.
`timescale 1ns / 1ps

module lrp_parse (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_accept,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output lrp_pkg::push_t   push,
    output lrp_pkg::result_t entry_lo,
    output lrp_pkg::result_t entry_hi
);

    typedef enum logic [11:0] {
        PH_FIRST  = 12'b0000_0000_0001,
        PH_CMD    = 12'b0000_0000_0010,
        PH_KLEN   = 12'b0000_0000_0100,
        PH_KEY    = 12'b0000_0000_1000,
        PH_ENC    = 12'b0000_0001_0000,
        PH_SEQ    = 12'b0000_0010_0000,
        PH_TS     = 12'b0000_0100_0000,
        PH_ARGC   = 12'b0000_1000_0000,
        PH_ALEN   = 12'b0001_0000_0000,
        PH_ARG    = 12'b0010_0000_0000,
        PH_SKIP   = 12'b0100_0000_0000,
        PH_BADVER = 12'b1000_0000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] key_length_reg, key_length_next;
    logic [31:0] byte_counter_reg, byte_counter_next;
    logic [6:0]  db_id_reg, db_id_next;
    logic [1:0]  store_type_reg, store_type_next;
    logic [31:0] record_ts_reg, record_ts_next;
    logic [31:0] arg_count_reg, arg_count_next;
    logic [31:0] arg_index_reg, arg_index_next;
    logic [31:0] arg_length_reg, arg_length_next;

    logic [31:0] cnt_inc;
    logic [31:0] idx_inc;
    logic [31:0] alen_shift;
    logic [31:0] argc_shift;
    logic [15:0] klen_shift;
    phase_t      key_done_phase;
    logic        complete;
    logic        badver;
    logic        data_hit;
    logic        active;
    logic        summary_hit;
    lrp_pkg::kind_t data_kind;
    lrp_pkg::result_t data_res;
    lrp_pkg::result_t sum_res;

    assign cnt_inc        = byte_counter_reg + 32'd1;
    assign idx_inc        = arg_index_reg + 32'd1;
    assign klen_shift     = {key_length_reg[7:0], in_byte};
    assign argc_shift     = {arg_count_reg[23:0], in_byte};
    assign alen_shift     = {arg_length_reg[23:0], in_byte};
    assign key_done_phase = (version_reg == lrp_pkg::VERSION_LEGACY) ? PH_SEQ : PH_TS;

    always_comb begin
        phase_next        = phase_reg;
        version_next      = version_reg;
        command_next      = command_reg;
        key_length_next   = key_length_reg;
        byte_counter_next = byte_counter_reg;
        db_id_next        = db_id_reg;
        store_type_next   = store_type_reg;
        record_ts_next    = record_ts_reg;
        arg_count_next    = arg_count_reg;
        arg_index_next    = arg_index_reg;
        arg_length_next   = arg_length_reg;
        complete          = 1'b0;
        badver            = 1'b0;
        data_hit          = 1'b0;
        data_kind         = lrp_pkg::KIND_KEY;
        active            = 1'b1;

        case (phase_reg)
            PH_FIRST: begin
                version_next      = lrp_pkg::VERSION_LEGACY;
                command_next      = 8'd0;
                key_length_next   = 16'd0;
                byte_counter_next = 32'd0;
                db_id_next        = 7'd0;
                store_type_next   = lrp_pkg::STORE_NONE;
                record_ts_next    = 32'd0;
                arg_count_next    = 32'd0;
                arg_index_next    = 32'd0;
                arg_length_next   = 32'd0;
                if (in_byte >= lrp_pkg::VERSION_MIN) begin
                    version_next = in_byte;
                    if (in_byte > lrp_pkg::VERSION_ENC) begin
                        phase_next        = PH_BADVER;
                        byte_counter_next = 32'd1;
                    end else begin
                        phase_next = PH_CMD;
                    end
                end else begin
                    command_next = in_byte;
                    phase_next   = PH_KLEN;
                end
            end
            PH_CMD: begin
                command_next      = in_byte;
                phase_next        = PH_KLEN;
                byte_counter_next = 32'd0;
            end
            PH_KLEN: begin
                key_length_next   = klen_shift;
                byte_counter_next = cnt_inc;
                if (cnt_inc == 32'd2) begin
                    byte_counter_next = 32'd0;
                    if (klen_shift != 16'd0) begin
                        phase_next = PH_KEY;
                    end else if (version_reg == lrp_pkg::VERSION_ENC) begin
                        phase_next = PH_ENC;
                    end else if (command_reg == 8'd0) begin
                        complete = 1'b1;
                    end else begin
                        phase_next = key_done_phase;
                    end
                end
            end
            PH_KEY: begin
                data_hit          = 1'b1;
                data_kind         = lrp_pkg::KIND_KEY;
                byte_counter_next = cnt_inc;
                if (cnt_inc == {16'd0, key_length_reg}) begin
                    if (version_reg == lrp_pkg::VERSION_ENC) begin
                        phase_next = PH_ENC;
                    end else if (command_reg == 8'd0) begin
                        complete = 1'b1;
                    end else begin
                        byte_counter_next = 32'd0;
                        phase_next        = key_done_phase;
                    end
                end
            end
            PH_ENC: begin
                db_id_next      = in_byte[6:0];
                store_type_next = in_byte[7] ? lrp_pkg::STORE_PERSIST : lrp_pkg::STORE_CACHE;
                if (command_reg == 8'd0) begin
                    complete = 1'b1;
                end else begin
                    byte_counter_next = 32'd0;
                    phase_next        = key_done_phase;
                end
            end
            PH_SEQ: begin
                byte_counter_next = cnt_inc;
                if (cnt_inc == 32'd8) begin
                    byte_counter_next = 32'd0;
                    phase_next        = PH_TS;
                end
            end
            PH_TS: begin
                record_ts_next    = {record_ts_reg[23:0], in_byte};
                byte_counter_next = cnt_inc;
                if (cnt_inc == 32'd4) begin
                    byte_counter_next = 32'd0;
                    if (in_last) begin
                        complete = 1'b1;
                    end else begin
                        phase_next = PH_ARGC;
                    end
                end
            end
            PH_ARGC: begin
                arg_count_next    = argc_shift;
                byte_counter_next = cnt_inc;
                if (cnt_inc == ((version_reg == lrp_pkg::VERSION_ENC) ? 32'd4 : 32'd1)) begin
                    byte_counter_next = 32'd0;
                    if (argc_shift == 32'd0) begin
                        complete = 1'b1;
                    end else begin
                        phase_next      = PH_ALEN;
                        arg_index_next  = 32'd0;
                        arg_length_next = 32'd0;
                    end
                end
            end
            PH_ALEN: begin
                arg_length_next   = alen_shift;
                byte_counter_next = cnt_inc;
                if (cnt_inc == ((version_reg < lrp_pkg::VERSION_WIDE) ? 32'd2 : 32'd4)) begin
                    byte_counter_next = 32'd0;
                    if (alen_shift != 32'd0) begin
                        phase_next = PH_ARG;
                    end else begin
                        // An empty argument closes at once.
                        arg_index_next = idx_inc;
                        if (idx_inc == arg_count_reg) begin
                            complete = 1'b1;
                        end else begin
                            phase_next      = PH_ALEN;
                            arg_length_next = 32'd0;
                        end
                    end
                end
            end
            PH_ARG: begin
                data_hit          = 1'b1;
                data_kind         = lrp_pkg::KIND_ARG;
                byte_counter_next = cnt_inc;
                if (cnt_inc == arg_length_reg) begin
                    arg_index_next = idx_inc;
                    if (idx_inc == arg_count_reg) begin
                        complete = 1'b1;
                    end else begin
                        phase_next        = PH_ALEN;
                        byte_counter_next = 32'd0;
                        arg_length_next   = 32'd0;
                    end
                end
            end
            PH_BADVER: begin
                byte_counter_next = cnt_inc;
                if (cnt_inc == 32'd3) begin
                    badver = 1'b1;
                end
            end
            PH_SKIP: begin
                // Trailing bytes after a finished record are dropped.
                active = 1'b0;
                if (in_last) begin
                    phase_next = PH_FIRST;
                end
            end
            default: begin
                active     = 1'b0;
                phase_next = PH_FIRST;
            end
        endcase

        summary_hit = active && (complete || badver || in_last);
        if (summary_hit) begin
            phase_next = in_last ? PH_FIRST : PH_SKIP;
        end
    end

    always_comb begin
        data_res              = '0;
        data_res.kind         = data_kind;
        data_res.payload_byte = in_byte;
        data_res.arg_index    = (data_kind == lrp_pkg::KIND_ARG) ? arg_index_reg : 32'd0;
        data_res.status       = lrp_pkg::STATUS_OK;
        data_res.last         = !summary_hit;

        // The summary shows the fields as they stand after this byte.
        sum_res            = '0;
        sum_res.kind       = lrp_pkg::KIND_SUMMARY;
        sum_res.status     = complete ? lrp_pkg::STATUS_OK :
                             (badver ? lrp_pkg::STATUS_BADVER : lrp_pkg::STATUS_TRUNC);
        sum_res.command    = command_next;
        sum_res.version    = version_next;
        sum_res.key_length = key_length_next;
        sum_res.db_id      = db_id_next;
        sum_res.store_type = store_type_next;
        sum_res.record_ts  = record_ts_next;
        sum_res.arg_count  = arg_count_next;
        sum_res.last       = 1'b1;
    end

    assign push.lo  = in_accept && (data_hit || summary_hit);
    assign push.hi  = in_accept && data_hit && summary_hit;
    assign entry_lo = data_hit ? data_res : sum_res;
    assign entry_hi = sum_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
        end else if (in_accept) begin
            phase_reg <= phase_next;
        end
    end

    // Every record starts in the first-byte phase, which rewrites all fields.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            version_reg      <= version_next;
            command_reg      <= command_next;
            key_length_reg   <= key_length_next;
            byte_counter_reg <= byte_counter_next;
            db_id_reg        <= db_id_next;
            store_type_reg   <= store_type_next;
            record_ts_reg    <= record_ts_next;
            arg_count_reg    <= arg_count_next;
            arg_index_reg    <= arg_index_next;
            arg_length_reg   <= arg_length_next;
        end
    end

endmodule

>>> rtl/lrp_result_fifo.sv
// Small result queue that takes up to two results per cycle and gives one when out_ready is high.
`timescale 1ns / 1ps

module lrp_result_fifo #(
    parameter int DEPTH = lrp_pkg::RESULT_FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  lrp_pkg::push_t   push,
    input  lrp_pkg::result_t entry_lo,
    input  lrp_pkg::result_t entry_hi,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output lrp_pkg::result_t out_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 2);

    lrp_pkg::result_t entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus;
    logic [1:0]       push_n;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign push_n      = {1'b0, push.lo} + {1'b0, push.hi};
    assign pop         = out_valid && out_ready;
    assign wr_ptr_plus = ptr_inc(wr_ptr_reg);
    assign out_valid   = (count_reg != '0);
    assign out_entry   = entries[rd_ptr_reg];
    // Space for two words is kept free so that any byte can be taken.
    assign room        = (count_reg <= ROOM_LIMIT);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (push.hi) begin
            wr_ptr_next = ptr_inc(wr_ptr_plus);
        end else if (push.lo) begin
            wr_ptr_next = wr_ptr_plus;
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.lo) begin
            entries[wr_ptr_reg] <= entry_lo;
        end
        if (push.hi) begin
            entries[wr_ptr_plus] <= entry_hi;
        end
    end

endmodule

>>> rtl/log_record_parser_core.sv
// Top level of the log record parser: byte stream in, key, argument and summary words out.
`timescale 1ns / 1ps

// The parser takes one record byte per cycle on the slave side, tlast marking
// the final byte of the record buffer, and streams key and argument bytes out
// as they arrive, closing each record with one summary word that carries the
// status and the parsed header fields. Each accepted byte yields no, one or two
// output words; all of its parsing is done in the cycle it is accepted and its
// words are written to a result queue of FIFO_DEPTH words, which drains one
// word per cycle when the master side is ready. A byte is taken whenever the
// queue has room for two words, so with the master side ready the block
// sustains one byte per cycle; the only throttle is the queue filling up while
// the master side stalls. Words wait in the registered queue behind older ones.

module log_record_parser_core #(
    parameter int FIFO_DEPTH = lrp_pkg::RESULT_FIFO_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // payload_byte, arg_index, status, command, version,
                                    // key_length, db_id, store_type, record_ts,
                                    // arg_count, zero fill
    output logic [1:0]   m_tuser,   // result_kind
    output logic         m_tlast    // last
);

    lrp_pkg::push_t   push;
    lrp_pkg::result_t entry_lo;
    lrp_pkg::result_t entry_hi;
    lrp_pkg::result_t head;
    logic             in_accept;

    assign in_accept = s_tvalid && s_tready;

    lrp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .push      (push),
        .entry_lo  (entry_lo),
        .entry_hi  (entry_hi)
    );

    lrp_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .entry_lo  (entry_lo),
        .entry_hi  (entry_hi),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_entry (head)
    );

    assign m_tdata = {5'd0, head.arg_count, head.record_ts, head.store_type, head.db_id,
                      head.key_length, head.version, head.command, head.status,
                      head.arg_index, head.payload_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

>>> test/lrp_sb_pkg.sv
// Record scoreboard for the log record parser testbench: byte-level predictor and word checker.
`timescale 1ns / 1ps

package lrp_sb_pkg;

    import lrp_pkg::*;

    typedef enum logic [3:0] {
        P_FIRST, P_CMD, P_KLEN, P_KEY, P_ENC, P_SEQ, P_TS,
        P_ARGC, P_ALEN, P_ARG, P_SKIP, P_BADVER
    } parse_phase_t;

    class record_scoreboard;
        parse_phase_t phase;
        logic [7:0]   version;
        logic [7:0]   command;
        logic [15:0]  key_length;
        logic [31:0]  count;
        logic [6:0]   db_id;
        logic [1:0]   store_type;
        logic [31:0]  record_ts;
        logic [31:0]  arg_count;
        logic [31:0]  arg_index;
        logic [31:0]  arg_length;
        result_t      pending[$];
        int           failures;
        int           key_words;
        int           arg_words;
        int           summaries[3];

        function new();
            clear_record();
            failures  = 0;
            key_words = 0;
            arg_words = 0;
            summaries = '{0, 0, 0};
        endfunction

        function void clear_record();
            phase      = P_FIRST;
            version    = VERSION_LEGACY;
            command    = 8'd0;
            key_length = 16'd0;
            count      = 32'd0;
            db_id      = 7'd0;
            store_type = STORE_NONE;
            record_ts  = 32'd0;
            arg_count  = 32'd0;
            arg_index  = 32'd0;
            arg_length = 32'd0;
        endfunction

        function result_t data_word(kind_t kind, logic [7:0] b, logic [31:0] idx);
            result_t w;
            w = '0;
            w.kind = kind;
            w.payload_byte = b;
            w.arg_index = idx;
            return w;
        endfunction

        // A command of zero ends the record once the key (and encoding byte) are in.
        function bit key_done();
            if (command == 8'd0)
                return 1'b1;
            count = 32'd0;
            phase = (version == VERSION_LEGACY) ? P_SEQ : P_TS;
            return 1'b0;
        endfunction

        function bit after_key();
            if (version == VERSION_ENC) begin
                phase = P_ENC;
                return 1'b0;
            end
            return key_done();
        endfunction

        function bit arg_done();
            arg_index++;
            if (arg_index == arg_count)
                return 1'b1;
            phase = P_ALEN;
            count = 32'd0;
            arg_length = 32'd0;
            return 1'b0;
        endfunction

        // Works out the words that one accepted byte causes and queues them.
        function void note_byte(logic [7:0] b, logic lb);
            result_t fresh[$];
            result_t w;
            bit complete;
            bit badver;
            int unsigned lensize;
            complete = 1'b0;
            badver = 1'b0;
            case (phase)
                P_FIRST: begin
                    clear_record();
                    if (b >= VERSION_MIN) begin
                        version = b;
                        if (b > VERSION_ENC) begin
                            phase = P_BADVER;
                            count = 32'd1;
                        end else begin
                            phase = P_CMD;
                        end
                    end else begin
                        command = b;
                        phase = P_KLEN;
                        count = 32'd0;
                    end
                end
                P_CMD: begin
                    command = b;
                    phase = P_KLEN;
                    count = 32'd0;
                end
                P_KLEN: begin
                    key_length = {key_length[7:0], b};
                    count++;
                    if (count >= 2) begin
                        count = 32'd0;
                        if (key_length == 16'd0)
                            complete = after_key();
                        else
                            phase = P_KEY;
                    end
                end
                P_KEY: begin
                    fresh.push_back(data_word(KIND_KEY, b, 32'd0));
                    count++;
                    if (count >= {16'd0, key_length})
                        complete = after_key();
                end
                P_ENC: begin
                    db_id = b[6:0];
                    store_type = b[7] ? STORE_PERSIST : STORE_CACHE;
                    complete = key_done();
                end
                P_SEQ: begin
                    count++;
                    if (count >= 8) begin
                        count = 32'd0;
                        phase = P_TS;
                    end
                end
                P_TS: begin
                    record_ts = {record_ts[23:0], b};
                    count++;
                    if (count >= 4) begin
                        count = 32'd0;
                        if (lb)
                            complete = 1'b1;
                        else
                            phase = P_ARGC;
                    end
                end
                P_ARGC: begin
                    arg_count = {arg_count[23:0], b};
                    count++;
                    if (count >= ((version == VERSION_ENC) ? 4 : 1)) begin
                        count = 32'd0;
                        if (arg_count == 32'd0) begin
                            complete = 1'b1;
                        end else begin
                            phase = P_ALEN;
                            arg_index = 32'd0;
                            arg_length = 32'd0;
                        end
                    end
                end
                P_ALEN: begin
                    lensize = (version < VERSION_WIDE) ? 2 : 4;
                    arg_length = {arg_length[23:0], b};
                    count++;
                    if (count >= lensize) begin
                        count = 32'd0;
                        if (arg_length == 32'd0)
                            complete = arg_done();
                        else
                            phase = P_ARG;
                    end
                end
                P_ARG: begin
                    fresh.push_back(data_word(KIND_ARG, b, arg_index));
                    count++;
                    if (count >= arg_length)
                        complete = arg_done();
                end
                P_BADVER: begin
                    count++;
                    if (count >= 3)
                        badver = 1'b1;
                end
                default: begin
                    // Bytes after a finished record are dropped until its buffer ends.
                    if (lb)
                        phase = P_FIRST;
                    return;
                end
            endcase

            if (complete || badver || lb) begin
                w = '0;
                w.kind = KIND_SUMMARY;
                w.status = complete ? STATUS_OK : (badver ? STATUS_BADVER : STATUS_TRUNC);
                w.command = command;
                w.version = version;
                w.key_length = key_length;
                w.db_id = db_id;
                w.store_type = store_type;
                w.record_ts = record_ts;
                w.arg_count = arg_count;
                fresh.push_back(w);
                phase = lb ? P_FIRST : P_SKIP;
            end
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                pending.push_back(fresh[i]);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        // Fields of tdata from the lowest bit up: payload_byte, arg_index, status,
        // command, version, key_length, db_id, store_type, record_ts, arg_count.
        function void check_word(logic [1:0] kind, logic [151:0] bits, logic last);
            result_t want;
            if (pending.size() == 0) begin
                $error("unexpected word: kind %0d, tdata 0x%0h", kind, bits);
                failures++;
                return;
            end
            want = pending.pop_front();
            compare_field("result_kind",  want.kind,         kind);
            compare_field("payload_byte", want.payload_byte, bits[7:0]);
            compare_field("arg_index",    want.arg_index,    bits[39:8]);
            compare_field("status",       want.status,       bits[41:40]);
            compare_field("command",      want.command,      bits[49:42]);
            compare_field("version",      want.version,      bits[57:50]);
            compare_field("key_length",   want.key_length,   bits[73:58]);
            compare_field("db_id",        want.db_id,        bits[80:74]);
            compare_field("store_type",   want.store_type,   bits[82:81]);
            compare_field("record_ts",    want.record_ts,    bits[114:83]);
            compare_field("arg_count",    want.arg_count,    bits[146:115]);
            compare_field("last",         want.last,         last);
            case (want.kind)
                KIND_KEY: key_words++;
                KIND_ARG: arg_words++;
                default:  summaries[want.status]++;
            endcase
        endfunction
    endclass

endpackage

>>> test/tb_log_record_parser_core.sv
// Testbench top for the log record parser: drives record bytes and checks every output word.
`timescale 1ns / 1ps

module tb_log_record_parser_core;

    import lrp_pkg::*;
    import lrp_sb_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int ITEM_TARGET  = 1850;
    localparam int DRAIN_CYCLES = 16;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    record_scoreboard sb;
    logic [7:0]  rec_bytes[$];
    int unsigned rec_cap;
    int          significant;
    int          bytes_sent;
    int          cycles = 0;
    bit          smooth = 1'b0;

    log_record_parser_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tuser, m_tdata, m_tlast);
    end

    // Mostly no gap, else short gaps, now and then a long one, none at all while smooth is set.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (smooth || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial begin
        int run;
        int gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (smooth) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                run = $urandom_range(1, 12);
                m_tready <= 1'b1;
                repeat (run) @(posedge aclk);
                gap = gap_len();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    function automatic void put_byte(logic [7:0] b);
        if (rec_bytes.size() < rec_cap)
            rec_bytes.push_back(b);
    endfunction

    function automatic void put_be(logic [31:0] v, int n);
        for (int i = n - 1; i >= 0; i--)
            put_byte(v[8*i +: 8]);
    endfunction

    // Builds one record buffer: mostly well formed with random content, some of
    // it cut short, some with trailing bytes, plus broken versions and noise.
    function automatic void build_record();
        int unsigned sel;
        int unsigned vsel;
        int unsigned klen;
        int unsigned argc;
        int unsigned alen;
        int unsigned lsz;
        int unsigned target;
        logic [7:0]  ver;
        logic [7:0]  cmd;
        bit          big;
        rec_bytes = {};
        rec_cap = 32'hffff_ffff;
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
            significant = rec_bytes.size();
            return;
        end
        if (sel < 10) begin
            put_byte(8'($urandom_range(130, 255)));
            repeat ($urandom_range(0, 5)) put_byte(8'($urandom_range(0, 255)));
            significant = rec_bytes.size();
            return;
        end
        // Large length and count fields; the buffer is cut off early to keep runs short.
        big = ($urandom_range(0, 9) == 0);
        if (big)
            rec_cap = $urandom_range(1, 40);
        vsel = $urandom_range(0, 3);
        if (vsel == 0) begin
            ver = VERSION_LEGACY;
            cmd = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 126));
        end else begin
            ver = (vsel == 1) ? VERSION_MIN : ((vsel == 2) ? VERSION_WIDE : VERSION_ENC);
            cmd = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
            put_byte(ver);
        end
        put_byte(cmd);
        if (big)
            klen = $urandom_range(0, 65535);
        else
            klen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        put_be(klen, 2);
        for (int unsigned i = 0; i < klen && rec_bytes.size() < rec_cap; i++)
            put_byte(8'($urandom_range(0, 255)));
        if (ver == VERSION_ENC)
            put_byte(8'($urandom_range(0, 255)));
        if (cmd != 8'd0) begin
            if (ver == VERSION_LEGACY)
                repeat (8) put_byte(8'($urandom_range(0, 255)));
            put_be($urandom, 4);
            if ($urandom_range(0, 9) != 0) begin
                if (ver == VERSION_ENC)
                    argc = big ? $urandom : $urandom_range(0, 4);
                else
                    argc = big ? $urandom_range(0, 255) : $urandom_range(0, 4);
                put_be(argc, (ver == VERSION_ENC) ? 4 : 1);
                lsz = (ver < VERSION_WIDE) ? 2 : 4;
                for (int unsigned j = 0; j < argc && rec_bytes.size() < rec_cap; j++) begin
                    if (big)
                        alen = (lsz == 2) ? $urandom_range(0, 65535) : $urandom;
                    else
                        alen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
                    put_be(alen, lsz);
                    for (int unsigned i = 0; i < alen && rec_bytes.size() < rec_cap; i++)
                        put_byte(8'($urandom_range(0, 255)));
                end
            end
        end
        if (!big && $urandom_range(0, 7) == 0) begin
            target = $urandom_range(1, rec_bytes.size());
            while (rec_bytes.size() > target)
                void'(rec_bytes.pop_back());
        end
        significant = rec_bytes.size();
        if (!big && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) rec_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lb);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lb;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_byte(b, lb);
        bytes_sent++;
    endtask

    task automatic send_record();
        foreach (rec_bytes[i])
            send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
    endtask

    initial begin
        int items;
        int rec_no;
        sb = new();
        bytes_sent = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        s_tlast  <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Legacy record with command zero and an empty key.
        rec_bytes = {8'h00, 8'h00, 8'h00};
        send_record();
        // Encoded version, command zero, one key byte, encoding byte with every bit set.
        rec_bytes = {VERSION_ENC, 8'h00, 8'h00, 8'h01, 8'hff, 8'hff};
        send_record();
        // Record that ends on the last timestamp byte.
        rec_bytes = {VERSION_MIN, 8'hff, 8'h00, 8'h00, 8'hde, 8'had, 8'hbe, 8'hef};
        send_record();
        // Unknown version, reported on the third byte and cut short before it.
        rec_bytes = {8'hff, 8'h01, 8'h02};
        send_record();
        rec_bytes = {8'h82, 8'h55};
        send_record();
        // A buffer holding only a legacy command byte.
        rec_bytes = {8'h7e};
        send_record();

        items = 0;
        rec_no = 0;
        while (items < ITEM_TARGET) begin
            if (rec_no % 8 == 0)
                smooth = ($urandom_range(0, 3) == 0);
            build_record();
            send_record();
            items += significant;
            rec_no++;
        end
        s_tvalid <= 1'b0;
        smooth = 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes in %0d random records; checked %0d key and %0d argument words.",
                 bytes_sent, rec_no, sb.key_words, sb.arg_words);
        $display("Record summaries: %0d complete, %0d truncated, %0d with an unknown version.",
                 sb.summaries[STATUS_OK], sb.summaries[STATUS_TRUNC],
                 sb.summaries[STATUS_BADVER]);
        if (sb.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
